// ----- rtl/core/cla_pkg.sv -----
// cla_pkg: shared types, constants and character helpers for the command line assembler
// used by cla_ctrl, cla_datapath and command_line_assembler; no dependencies
package cla_pkg;

    localparam int STORE_DEPTH_DEFAULT = 64;
    localparam int MAX_RESULTS         = 64;
    localparam int COUNT_W             = $clog2(MAX_RESULTS);

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_DEL   = 8'h7f;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CASE_DIFF  = 8'd32;
    localparam logic [7:0] COUNT_MAX  = 8'd255;

    localparam logic OP_RECEIVE = 1'b0;
    localparam logic OP_FETCH   = 1'b1;

    localparam logic KIND_ECHO    = 1'b0;
    localparam logic KIND_COMMAND = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_ERASE_SPACE,
        ST_ERASE_BS
    } state_t;

    typedef enum logic [2:0] {
        EM_ECHO,
        EM_SPACE,
        EM_BS,
        EM_EMPTY,
        EM_CHAR
    } emit_sel_t;

    typedef struct packed {
        logic      accept;
        logic      apply;
        logic      emit;
        emit_sel_t emit_sel;
        logic      read_first;
        logic      read_next;
    } ctrl_cmd_t;

    typedef struct packed {
        logic op_fetch;
        logic echo_en;
        logic erase;
        logic pending_zero;
        logic out_free;
        logic fetch_done;
    } dp_status_t;

    function automatic logic storable(input logic [7:0] c);
        logic alpha_hi;
        logic alpha_lo;
        logic digit;
        alpha_hi = (c >= 8'h41) && (c <= 8'h5a);
        alpha_lo = (c >= 8'h61) && (c <= 8'h7a);
        digit    = (c >= 8'h30) && (c <= 8'h39);
        return alpha_hi || alpha_lo || digit || (c == CHAR_SPACE) || (c == 8'h2b)
            || (c == 8'h2d) || (c == 8'h2e) || (c == CHAR_NUL);
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if ((c >= 8'h61) && (c <= 8'h7a))
        begin
            r = c - CASE_DIFF;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/cla_ctrl.sv -----
// cla_ctrl: sequencing state machine for the command line assembler
// depends on cla_pkg; drives cla_datapath through ctrl_cmd_t, reads dp_status_t
module cla_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cla_pkg::dp_status_t status,
    output cla_pkg::ctrl_cmd_t  cmd
);
    import cla_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (status.op_fetch)
                begin
                    if (status.pending_zero)
                    begin
                        if (status.out_free)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = ST_ERASE_SPACE;
                    end
                end
                else if (status.out_free || !status.echo_en)
                begin
                    state_next = status.erase ? ST_ERASE_SPACE : ST_IDLE;
                end
            end
            ST_ERASE_SPACE:
            begin
                // shared by fetch streaming and erase space
                if (status.out_free)
                begin
                    if (status.op_fetch)
                    begin
                        if (status.fetch_done)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = ST_ERASE_BS;
                    end
                end
            end
            ST_ERASE_BS:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready       = 1'b0;
        cmd.accept     = 1'b0;
        cmd.apply      = 1'b0;
        cmd.emit       = 1'b0;
        cmd.emit_sel   = EM_ECHO;
        cmd.read_first = 1'b0;
        cmd.read_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_START:
            begin
                if (status.op_fetch)
                begin
                    if (status.pending_zero)
                    begin
                        cmd.emit     = status.out_free;
                        cmd.emit_sel = EM_EMPTY;
                    end
                    else
                    begin
                        cmd.read_first = 1'b1;
                    end
                end
                else if (status.out_free || !status.echo_en)
                begin
                    cmd.apply    = 1'b1;
                    cmd.emit     = status.echo_en;
                    cmd.emit_sel = EM_ECHO;
                end
            end
            ST_ERASE_SPACE:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.op_fetch)
                    begin
                        cmd.emit_sel  = EM_CHAR;
                        cmd.read_next = 1'b1;
                    end
                    else
                    begin
                        cmd.emit_sel = EM_SPACE;
                    end
                end
            end
            ST_ERASE_BS:
            begin
                cmd.emit     = status.out_free;
                cmd.emit_sel = EM_BS;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/core/cla_datapath.sv -----
// cla_datapath: ring store, indexes, command count, line editing and output register
// depends on cla_pkg; commanded by cla_ctrl
module cla_datapath #(
    parameter int STORE_DEPTH = cla_pkg::STORE_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cla_pkg::ctrl_cmd_t  cmd,
    output cla_pkg::dp_status_t status,
    input  logic                cfg_we,
    input  logic                cfg_data,
    input  logic                operation,
    input  logic [7:0]          rx_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                kind,
    output logic [7:0]          data,
    output logic                last
);
    import cla_pkg::*;

    localparam int IDX_W = (STORE_DEPTH > 2) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(STORE_DEPTH - 1);
    localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(MAX_RESULTS - 1);

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
        return (i == IDX_TOP) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_TOP : i - 1'b1;
    endfunction

    logic [7:0]         line_store_reg [STORE_DEPTH];
    logic [7:0]         rd_data_reg;
    logic [IDX_W-1:0]   wi_reg, wi_next;
    logic [IDX_W-1:0]   ri_reg, ri_next;
    logic [7:0]         pending_reg, pending_next;
    logic [7:0]         prev_reg, prev_next;
    logic               echo_reg;
    logic               op_reg;
    logic [7:0]         byte_reg;
    logic [COUNT_W-1:0] n_reg, n_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_kind_reg, out_kind_next;
    logic [7:0]         out_data_reg, out_data_next;
    logic               out_last_reg, out_last_next;

    logic               is_nl, pair, is_bs, ring_empty, drop, erase, do_store;
    logic [7:0]         c_eff;
    logic [IDX_W-1:0]   ri_inc;
    logic               fetch_done;
    logic               mem_we, mem_re;
    logic [IDX_W-1:0]   mem_raddr;

    // receive editing
    always_comb
    begin
        is_nl      = (byte_reg == CHAR_LF) || (byte_reg == CHAR_CR);
        pair       = ((byte_reg == CHAR_LF) && (prev_reg == CHAR_CR))
                  || ((byte_reg == CHAR_CR) && (prev_reg == CHAR_LF));
        c_eff      = is_nl ? CHAR_NUL : byte_reg;
        ring_empty = (wi_reg == ri_reg);
        drop       = pair || (ring_empty && (c_eff == CHAR_SPACE));
        is_bs      = (c_eff == CHAR_BS) || (c_eff == CHAR_DEL);
        erase      = !drop && is_bs && !ring_empty;
        do_store   = !drop && !is_bs && storable(c_eff);
    end

    // fetch stream end
    always_comb
    begin
        ri_inc     = ring_next(ri_reg);
        fetch_done = (rd_data_reg == CHAR_NUL) || (ri_inc == wi_reg) || (n_reg == COUNT_LAST);
    end

    always_comb
    begin
        status.op_fetch     = (op_reg == OP_FETCH);
        status.echo_en      = echo_reg;
        status.erase        = erase;
        status.pending_zero = (pending_reg == 8'd0);
        status.out_free     = !out_valid_reg || out_ready;
        status.fetch_done   = fetch_done;
    end

    // state updates
    always_comb
    begin
        wi_next      = wi_reg;
        ri_next      = ri_reg;
        pending_next = pending_reg;
        prev_next    = prev_reg;
        n_next       = n_reg;
        if (cmd.apply)
        begin
            prev_next = pair ? CHAR_NUL : byte_reg;
            if (is_nl && !pair && (pending_reg != COUNT_MAX))
            begin
                pending_next = pending_reg + 8'd1;
            end
            if (erase)
            begin
                wi_next = ring_prev(wi_reg);
            end
            else if (do_store)
            begin
                wi_next = ring_next(wi_reg);
            end
        end
        if (cmd.read_first)
        begin
            n_next = '0;
        end
        if (cmd.read_next)
        begin
            ri_next = ri_inc;
            n_next  = n_reg + 1'b1;
            if (fetch_done)
            begin
                pending_next = pending_reg - 8'd1;
            end
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_kind_next  = out_kind_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            case (cmd.emit_sel)
                EM_ECHO:
                begin
                    out_kind_next = KIND_ECHO;
                    out_data_next = byte_reg;
                    out_last_next = !erase;
                end
                EM_SPACE:
                begin
                    out_kind_next = KIND_ECHO;
                    out_data_next = CHAR_SPACE;
                    out_last_next = 1'b0;
                end
                EM_BS:
                begin
                    out_kind_next = KIND_ECHO;
                    out_data_next = CHAR_BS;
                    out_last_next = 1'b1;
                end
                EM_EMPTY:
                begin
                    out_kind_next = KIND_COMMAND;
                    out_data_next = CHAR_NUL;
                    out_last_next = 1'b1;
                end
                EM_CHAR:
                begin
                    out_kind_next = KIND_COMMAND;
                    out_data_next = rd_data_reg;
                    out_last_next = fetch_done;
                end
                default:
                begin
                    out_kind_next = KIND_ECHO;
                    out_data_next = CHAR_NUL;
                    out_last_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wi_reg        <= '0;
            ri_reg        <= '0;
            pending_reg   <= '0;
            prev_reg      <= '0;
            n_reg         <= '0;
            echo_reg      <= 1'b0;
            op_reg        <= OP_RECEIVE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wi_reg        <= wi_next;
            ri_reg        <= ri_next;
            pending_reg   <= pending_next;
            prev_reg      <= prev_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                echo_reg <= cfg_data;
            end
            if (cmd.accept)
            begin
                op_reg <= operation;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        if (cmd.accept)
        begin
            byte_reg <= rx_byte;
        end
    end

    // ring store
    always_comb
    begin
        mem_we    = cmd.apply && do_store;
        mem_re    = cmd.read_first || cmd.read_next;
        mem_raddr = cmd.read_next ? ri_inc : ri_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_store_reg[wi_reg] <= to_upper(c_eff);
        end
        if (mem_re)
        begin
            rd_data_reg <= line_store_reg[mem_raddr];
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign data      = out_data_reg;
    assign last      = out_last_reg;

endmodule

// ----- rtl/core/command_line_assembler.sv -----
// command_line_assembler: top level, joins cla_ctrl and cla_datapath
// depends on cla_pkg, cla_ctrl, cla_datapath
//
// input channel (in_valid/in_ready, operation, rx_byte): operation 0 is a receive
// of rx_byte, operation 1 fetches the oldest waiting command. one request is in
// work at a time; in_ready is high only while the block is idle.
// output channel (out_valid/out_ready, kind, data, last): kind 0 is a byte sent
// back to the terminal, kind 1 a command character; last marks the final result
// of a request. results leave through a single output register.
// config channel (cfg_valid/cfg_ready, cfg_data): sets echo enable, always ready.
// receive: accepted in idle; the start state edits the line and loads the echo;
// an erase adds the erase space and erase backspace states for space and 0x08.
// fetch: accepted in idle, the start state reads the ring store first, then one
// character per cycle unless stalled, bounded by the single store read port.
// a stalled receiver holds the output register and the sequencer waits on it;
// no result is lost. reset clears indexes, command count, echo enable and the
// output valid; store contents stay undefined until written.
module command_line_assembler #(
    parameter int STORE_DEPTH = cla_pkg::STORE_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       operation,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       kind,
    output logic [7:0] data,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);
    import cla_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    cla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    cla_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .operation (operation),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .data      (data),
        .last      (last)
    );

endmodule

// ----- rtl/core/cla_checker.sv -----
// cla_checker: port level assertions for command_line_assembler
// no package dependency; attached to the top level by the bind below
module cla_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       kind,
    input logic [7:0] data,
    input logic       last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data) && $stable(kind) && $stable(last))
        else $error("stalled result changed");

    // one request in work at a time
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted back to back");

    // the next result of a request follows a non-final one without a gap
    a_busy_after_mid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
        else $error("no result after a non-final one");

    // a result waiting while idle is the final one of its request
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && out_valid |-> last)
        else $error("idle with a non-final result pending");

endmodule

bind command_line_assembler cla_checker u_cla_checker (.*);

// ----- tb/sv/command_line_assembler_tb.sv -----
// command_line_assembler_tb: self-checking bench for the terminal line assembler
// drives receive and fetch requests and echo writes, predicts every result and compares
// depends on cla_pkg and command_line_assembler
module command_line_assembler_tb;

    import cla_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int DEPTH        = STORE_DEPTH_DEFAULT;
    localparam int PTR_W        = $clog2(DEPTH);
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 10;

    typedef logic [PTR_W-1:0] ring_ptr_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } line_result_t;

    typedef struct packed {
        logic         is_cfg;
        logic         op;
        logic [7:0]   value;
        logic         typed;
        logic [1:0]   n;
        line_result_t r0;
        line_result_t r1;
        line_result_t r2;
    } stim_row_t;

    localparam line_result_t NO_RES      = '0;
    localparam line_result_t EMPTY_FETCH = '{KIND_COMMAND, CHAR_NUL, 1'b1};

    localparam stim_row_t DIRECTED_ROWS [26] = '{
        '{1'b0, OP_FETCH,   8'h00,     1'b1, 2'd1, EMPTY_FETCH, NO_RES, NO_RES},
        '{1'b0, OP_RECEIVE, CHAR_BS,   1'b1, 2'd0, NO_RES, NO_RES, NO_RES},
        '{1'b0, OP_RECEIVE, CHAR_SPACE, 1'b1, 2'd0, NO_RES, NO_RES, NO_RES},
        '{1'b1, OP_RECEIVE, 8'h01,     1'b0, 2'd0, NO_RES, NO_RES, NO_RES},
        '{1'b0, OP_RECEIVE, CHAR_NUL,  1'b1, 2'd1,
            '{KIND_ECHO, CHAR_NUL, 1'b1}, NO_RES, NO_RES},
        '{1'b0, OP_RECEIVE, 8'hff,     1'b1, 2'd1,
            '{KIND_ECHO, 8'hff, 1'b1}, NO_RES, NO_RES},
        '{1'b0, OP_RECEIVE, 8'h61,     1'b0, 2'd0, NO_RES, NO_RES, NO_RES},
        '{1'b0, OP_RECEIVE, 8'h7a,     1'b0, 2'd0, NO_RES, NO_RES, NO_RES},
        '{1'b0, OP_RECEIVE, CHAR_DEL,  1'b1, 2'd3,
            '{KIND_ECHO, CHAR_DEL, 1'b0}, '{KIND_ECHO, CHAR_SPACE, 1'b0},
            '{KIND_ECHO, CHAR_BS, 1'b1}},
        '{1'b0, OP_RECEIVE, 8'h30,     1'b0, 2'd0, NO_RES, NO_RES, NO_RES},
        '{1'b0, OP_RECEIVE, 8'h39,     1'b0, 2'd0, NO_RES, NO_RES, NO_RES},
        '{1'b0, OP_RECEIVE, 8'h2b,     1'b0, 2'd0, NO_RES, NO_RES, NO_RES},
        '{1'b0, OP_RECEIVE, 8'h2d,     1'b0, 2'd0, NO_RES, NO_RES, NO_RES},
        '{1'b0, OP_RECEIVE, 8'h2e,     1'b0, 2'd0, NO_RES, NO_RES, NO_RES},
        '{1'b0, OP_RECEIVE, CHAR_SPACE, 1'b0, 2'd0, NO_RES, NO_RES, NO_RES},
        '{1'b0, OP_RECEIVE, 8'h5a,     1'b0, 2'd0, NO_RES, NO_RES, NO_RES},
        '{1'b0, OP_RECEIVE, 8'h41,     1'b0, 2'd0, NO_RES, NO_RES, NO_RES},
        '{1'b0, OP_RECEIVE, CHAR_CR,   1'b1, 2'd1,
            '{KIND_ECHO, CHAR_CR, 1'b1}, NO_RES, NO_RES},
        '{1'b0, OP_RECEIVE, CHAR_LF,   1'b1, 2'd1,
            '{KIND_ECHO, CHAR_LF, 1'b1}, NO_RES, NO_RES},
        '{1'b0, OP_FETCH,   8'hff,     1'b0, 2'd0, NO_RES, NO_RES, NO_RES},
        '{1'b0, OP_FETCH,   8'h00,     1'b1, 2'd1, EMPTY_FETCH, NO_RES, NO_RES},
        '{1'b1, OP_RECEIVE, 8'h00,     1'b0, 2'd0, NO_RES, NO_RES, NO_RES},
        '{1'b0, OP_RECEIVE, CHAR_LF,   1'b1, 2'd0, NO_RES, NO_RES, NO_RES},
        '{1'b0, OP_RECEIVE, CHAR_CR,   1'b1, 2'd0, NO_RES, NO_RES, NO_RES},
        '{1'b0, OP_FETCH,   8'h5a,     1'b0, 2'd0, NO_RES, NO_RES, NO_RES},
        '{1'b0, OP_FETCH,   8'ha5,     1'b0, 2'd0, NO_RES, NO_RES, NO_RES}
    };

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       operation;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_ready;
    logic       kind;
    logic [7:0] data;
    logic       last;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_data;

    // line assembler prediction state
    logic [7:0] ring_mem [DEPTH];
    bit         ring_written [DEPTH];
    ring_ptr_t  wr_ptr;
    ring_ptr_t  rd_ptr;
    logic [7:0] cmd_count;
    logic [7:0] prev_byte;
    logic       echo_on;

    line_result_t fresh[$];
    line_result_t results_due[$];

    int   error_count;
    int   requests_sent;
    int   tx_idle_pct;
    int   rx_idle_pct;
    logic hold_off_req;

    command_line_assembler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .data      (data),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(CLK_PERIOD * 1_000_000);
        $display("Test completed with failures");
        $finish;
    end

    function automatic void predict_request(input logic op, input logic [7:0] b);
        logic [7:0] c;
        logic [7:0] ch;
        logic       drop;
        c = b;
        drop = 1'b0;
        fresh.delete();
        if (op == OP_RECEIVE)
        begin
            if (echo_on)
            begin
                fresh.push_back('{KIND_ECHO, c, 1'b0});
            end
            if (c == CHAR_LF || c == CHAR_CR)
            begin
                if ((c == CHAR_LF && prev_byte == CHAR_CR) ||
                    (c == CHAR_CR && prev_byte == CHAR_LF))
                begin
                    prev_byte = CHAR_NUL;
                    drop = 1'b1;
                end
                else
                begin
                    if (cmd_count != COUNT_MAX)
                    begin
                        cmd_count = cmd_count + 1'b1;
                    end
                    prev_byte = c;
                    c = CHAR_NUL;
                end
            end
            else
            begin
                prev_byte = c;
            end
            if (!drop && wr_ptr == rd_ptr && c == CHAR_SPACE)
            begin
                drop = 1'b1;
            end
            if (!drop)
            begin
                if (c == CHAR_BS || c == CHAR_DEL)
                begin
                    if (wr_ptr != rd_ptr)
                    begin
                        wr_ptr = (wr_ptr == '0) ? ring_ptr_t'(DEPTH - 1) : wr_ptr - 1'b1;
                        fresh.push_back('{KIND_ECHO, CHAR_SPACE, 1'b0});
                        fresh.push_back('{KIND_ECHO, CHAR_BS, 1'b0});
                    end
                end
                else if ((c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a) ||
                         (c >= 8'h30 && c <= 8'h39) || c == CHAR_SPACE || c == 8'h2b ||
                         c == 8'h2d || c == 8'h2e || c == CHAR_NUL)
                begin
                    if (c >= 8'h61 && c <= 8'h7a)
                    begin
                        c = c - 8'd32;
                    end
                    ring_mem[wr_ptr] = c;
                    ring_written[wr_ptr] = 1'b1;
                    wr_ptr = (wr_ptr == ring_ptr_t'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
                end
            end
        end
        else
        begin
            if (cmd_count == 8'd0)
            begin
                fresh.push_back('{KIND_COMMAND, CHAR_NUL, 1'b0});
            end
            else
            begin
                do
                begin
                    ch = ring_mem[rd_ptr];
                    fresh.push_back('{KIND_COMMAND, ch, 1'b0});
                    rd_ptr = (rd_ptr == ring_ptr_t'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
                end
                while (ch != CHAR_NUL && rd_ptr != wr_ptr && fresh.size() < MAX_RESULTS);
                cmd_count = cmd_count - 1'b1;
            end
        end
        if (fresh.size() > 0)
        begin
            fresh[fresh.size() - 1].last = 1'b1;
        end
    endfunction

    task automatic offer_request(input logic op, input logic [7:0] b);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        in_valid  <= 1'b1;
        operation <= op;
        rx_byte   <= b;
        do @(posedge clk); while (!in_ready);
        requests_sent++;
    endtask

    task automatic send_request(input logic op, input logic [7:0] b);
        ring_ptr_t  p;
        logic [7:0] ch;
        int         n;
        bit         safe;
        // a fetch must never walk into a ring entry that was never written
        if (op == OP_FETCH && cmd_count != 8'd0)
        begin
            p = rd_ptr;
            n = 0;
            safe = 1'b1;
            do
            begin
                if (!ring_written[p])
                begin
                    safe = 1'b0;
                end
                ch = ring_mem[p];
                p = (p == ring_ptr_t'(DEPTH - 1)) ? '0 : p + 1'b1;
                n++;
            end
            while (safe && ch != CHAR_NUL && p != wr_ptr && n < MAX_RESULTS);
            if (!safe)
            begin
                op = OP_RECEIVE;
                b = 8'h51;
            end
        end
        offer_request(op, b);
        predict_request(op, b);
        foreach (fresh[k]) results_due.push_back(fresh[k]);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_echo(input logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        echo_on = v;
    endtask

    function automatic logic [7:0] random_line_char();
        logic [7:0] c;
        case ($urandom_range(5))
            0: c = 8'h41 + 8'($urandom_range(25));
            1: c = 8'h61 + 8'($urandom_range(25));
            2: c = 8'h30 + 8'($urandom_range(9));
            3: c = ($urandom_range(2) == 0) ? 8'h2b : ($urandom_range(1) ? 8'h2d : 8'h2e);
            4: c = CHAR_SPACE;
            default: c = 8'h61 + 8'($urandom_range(25));
        endcase
        return c;
    endfunction

    task automatic send_line_end();
        case ($urandom_range(3))
            0: send_request(OP_RECEIVE, CHAR_CR);
            1: send_request(OP_RECEIVE, CHAR_LF);
            2:
            begin
                send_request(OP_RECEIVE, CHAR_CR);
                send_request(OP_RECEIVE, CHAR_LF);
            end
            default:
            begin
                send_request(OP_RECEIVE, CHAR_LF);
                send_request(OP_RECEIVE, CHAR_CR);
            end
        endcase
    endtask

    task automatic random_traffic(input int count);
        int first;
        int pick;
        first = requests_sent;
        while (requests_sent - first < count)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                repeat ($urandom_range(12))
                begin
                    send_request(OP_RECEIVE, random_line_char());
                    if ($urandom_range(9) == 0)
                    begin
                        send_request(OP_RECEIVE, $urandom_range(1) ? CHAR_BS : CHAR_DEL);
                    end
                end
                send_line_end();
                if ($urandom_range(9) < 7)
                begin
                    send_request(OP_FETCH, 8'($urandom));
                end
            end
            else if (pick < 70)
            begin
                repeat ($urandom_range(1, 3)) send_request(OP_FETCH, 8'($urandom));
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(1, 4)) send_request(1'($urandom), 8'($urandom));
            end
            else if (pick < 92)
            begin
                // line of 50 to 75 characters, may pass the ring size so the write point wraps
                repeat ($urandom_range(50, 75)) send_request(OP_RECEIVE, random_line_char());
                send_line_end();
                send_request(OP_FETCH, 8'($urandom));
            end
            else if (wr_ptr == rd_ptr && cmd_count == 8'd0)
            begin
                // command that fills the ring exactly
                send_request(OP_RECEIVE, 8'h41 + 8'($urandom_range(25)));
                repeat (DEPTH - 2) send_request(OP_RECEIVE, random_line_char());
                send_request(OP_RECEIVE, CHAR_CR);
                send_request(OP_FETCH, 8'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                begin
                    send_request(OP_RECEIVE, $urandom_range(1) ? CHAR_BS : CHAR_DEL);
                end
            end
        end
    endtask

    // receiver with random stalls and one long hold-off
    initial
    begin : drive_out_ready
        int  stall_left;
        bit  hold_done;
        out_ready  = 1'b0;
        stall_left = 0;
        hold_done  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_done)
            begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial
    begin : check_results
        line_result_t got;
        line_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got = '{kind, data, last};
                if (results_due.size() == 0)
                begin
                    if (error_count < MAX_REPORTS)
                    begin
                        $display("unexpected result: kind %0d data %02h last %0d",
                                 got.kind, got.data, got.last);
                    end
                    error_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got.kind !== want.kind || got.data !== want.data ||
                        got.last !== want.last)
                    begin
                        if (error_count < MAX_REPORTS)
                        begin
                            $display("mismatch: expected %0d %02h %0d, got %0d %02h %0d",
                                     want.kind, want.data, want.last,
                                     got.kind, got.data, got.last);
                        end
                        error_count++;
                    end
                end
            end
        end
    end

    initial
    begin : run_stimulus
        stim_row_t row;
        in_valid     = 1'b0;
        operation    = OP_RECEIVE;
        rx_byte      = 8'h00;
        cfg_valid    = 1'b0;
        cfg_data     = 1'b0;
        hold_off_req = 1'b0;
        rst_n        = 1'b0;
        error_count  = 0;
        requests_sent = 0;
        tx_idle_pct  = 21;
        rx_idle_pct  = 53;
        foreach (ring_written[i]) ring_written[i] = 1'b0;
        wr_ptr    = '0;
        rd_ptr    = '0;
        cmd_count = 8'd0;
        prev_byte = CHAR_NUL;
        echo_on   = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[i])
        begin
            row = DIRECTED_ROWS[i];
            if (row.is_cfg)
            begin
                settle();
                write_echo(row.value[0]);
            end
            else
            begin
                offer_request(row.op, row.value);
                predict_request(row.op, row.value);
                if (row.typed)
                begin
                    if (row.n > 0) results_due.push_back(row.r0);
                    if (row.n > 1) results_due.push_back(row.r1);
                    if (row.n > 2) results_due.push_back(row.r2);
                end
                else
                begin
                    foreach (fresh[k]) results_due.push_back(fresh[k]);
                end
            end
        end

        settle();
        write_echo(1'b1);
        random_traffic(65);
        hold_off_req <= 1'b1;
        random_traffic(65);

        settle();
        write_echo(1'b0);
        tx_idle_pct = 53;
        rx_idle_pct = 21;
        random_traffic(65);
        // sender pauses until every request has been answered
        settle();
        write_echo(1'b1);
        random_traffic(65);

        settle();
        write_echo(1'b0);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_traffic(130);

        settle();
        if (error_count == 0 && results_due.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
